// ===== design/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// shared constants, types and register indexes of the pressure compensation
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int DIV_NUM_W  = 32;
    localparam int DIV_DEN_W  = 18;
    localparam int DIV_STAGES = DIV_NUM_W;
    localparam int DIV_LAST   = DIV_STAGES - 1;

    typedef logic [DIV_NUM_W-1:0] t_div_num;
    typedef logic [DIV_DEN_W-1:0] t_div_den;

    localparam int TEMP_OFFSET = 4000;
    localparam int PCOEF_A     = 3038;
    localparam int PCOEF_B     = -7357;
    localparam int PCOEF_C     = 3791;
    localparam int P_MAX       = 262143;
    localparam int T_MAX       = 32767;
    localparam int T_MIN       = -32768;

    localparam logic [15:0] B7_SCALE = 16'd50000;

    typedef enum logic [2:0] {
        CFG_AC1_AC2 = 3'd0,
        CFG_AC3_AC4 = 3'd1,
        CFG_AC5_AC6 = 3'd2,
        CFG_B1_B2   = 3'd3,
        CFG_MC_MD   = 3'd4,
        CFG_OSS     = 3'd5
    } t_cfg_idx;

endpackage

// ===== design/bpc_div.sv =====
// ----------------------------------------------------------------------------
// bpc_div
// pipelined restoring divider, one quotient bit per stage, unsigned
// ----------------------------------------------------------------------------
module bpc_div (
    input  logic              i_clk,
    input  logic              i_en,
    input  bpc_pkg::t_div_num i_num,
    input  bpc_pkg::t_div_den i_den,
    output bpc_pkg::t_div_num o_quo
);

    bpc_pkg::t_div_den r_rem [bpc_pkg::DIV_STAGES];
    bpc_pkg::t_div_num r_quo [bpc_pkg::DIV_STAGES];
    bpc_pkg::t_div_den r_den [bpc_pkg::DIV_STAGES];

    bpc_pkg::t_div_den n_rem [bpc_pkg::DIV_STAGES];
    bpc_pkg::t_div_num n_quo [bpc_pkg::DIV_STAGES];
    bpc_pkg::t_div_den n_den [bpc_pkg::DIV_STAGES];

    always_comb begin
        bpc_pkg::t_div_den     p_rem;
        bpc_pkg::t_div_num     p_quo;
        bpc_pkg::t_div_den     p_den;
        logic [bpc_pkg::DIV_DEN_W:0] trial;
        for (int k = 0; k < bpc_pkg::DIV_STAGES; k++) begin
            if (k == 0) begin
                p_rem = '0;
                p_quo = i_num;
                p_den = i_den;
            end else begin
                p_rem = r_rem[k-1];
                p_quo = r_quo[k-1];
                p_den = r_den[k-1];
            end
            trial = {p_rem, p_quo[bpc_pkg::DIV_NUM_W-1]};
            if (trial >= {1'b0, p_den}) begin
                n_rem[k] = bpc_pkg::t_div_den'(trial - {1'b0, p_den});
                n_quo[k] = {p_quo[bpc_pkg::DIV_NUM_W-2:0], 1'b1};
            end else begin
                n_rem[k] = trial[bpc_pkg::DIV_DEN_W-1:0];
                n_quo[k] = {p_quo[bpc_pkg::DIV_NUM_W-2:0], 1'b0};
            end
            n_den[k] = p_den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < bpc_pkg::DIV_STAGES; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
                r_den[k] <= n_den[k];
            end
        end
    end

    assign o_quo = r_quo[bpc_pkg::DIV_STAGES-1];

endmodule

// ===== design/barometric_pressure_compensation.sv =====
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// integer temperature and pressure compensation, fully pipelined
// ----------------------------------------------------------------------------
// One word in per cycle, one result word out per cycle, while the result is
// taken. The pipe has two front stages, a 32-stage divider for the temperature
// term, six polynomial stages, a second 32-stage divider for the pressure
// quotient and three closing stages with the output register. When the result
// is not taken the whole pipe holds. The user must write coefficients through
// the config port only while the pipe is empty; the block does not enforce
// it. A zero divisor gives divide_fault with zero values.
module barometric_pressure_compensation (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [15:0]        i_raw_temperature,
    input  logic [23:0]        i_raw_pressure_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_temperature_tenths,
    output logic [17:0]        o_pressure_pa,
    output logic               o_divide_fault
);

    // configuration
    logic [31:0] r_ac1_ac2, r_ac3_ac4, r_ac5_ac6, r_b1_b2, r_mc_md;
    logic [1:0]  r_oss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac1_ac2 <= '0;
            r_ac3_ac4 <= '0;
            r_ac5_ac6 <= '0;
            r_b1_b2   <= '0;
            r_mc_md   <= '0;
            r_oss     <= '0;
        end else if (i_cfg_we) begin
            case (bpc_pkg::t_cfg_idx'(i_cfg_index))
                bpc_pkg::CFG_AC1_AC2: r_ac1_ac2 <= i_cfg_data;
                bpc_pkg::CFG_AC3_AC4: r_ac3_ac4 <= i_cfg_data;
                bpc_pkg::CFG_AC5_AC6: r_ac5_ac6 <= i_cfg_data;
                bpc_pkg::CFG_B1_B2:   r_b1_b2   <= i_cfg_data;
                bpc_pkg::CFG_MC_MD:   r_mc_md   <= i_cfg_data;
                bpc_pkg::CFG_OSS:     r_oss     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [15:0]        ac4, ac5, ac6;

    assign ac1 = $signed(r_ac1_ac2[31:16]);
    assign ac2 = $signed(r_ac1_ac2[15:0]);
    assign ac3 = $signed(r_ac3_ac4[31:16]);
    assign ac4 = r_ac3_ac4[15:0];
    assign ac5 = r_ac5_ac6[31:16];
    assign ac6 = r_ac5_ac6[15:0];
    assign b1  = $signed(r_b1_b2[31:16]);
    assign b2  = $signed(r_b1_b2[15:0]);
    assign mc  = $signed(r_mc_md[31:16]);
    assign md  = $signed(r_mc_md[15:0]);

    logic en;
    logic r_out_v;

    assign en         = !r_out_v || i_out_ready;
    assign o_in_ready = en;

    // valid chain
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v, r9_v, r10_v;
    logic r_d1_v [bpc_pkg::DIV_STAGES];
    logic r_d2_v [bpc_pkg::DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0; r4_v <= 1'b0;
            r5_v <= 1'b0; r6_v <= 1'b0; r7_v <= 1'b0; r8_v <= 1'b0;
            r9_v <= 1'b0; r10_v <= 1'b0; r_out_v <= 1'b0;
            for (int k = 0; k < bpc_pkg::DIV_STAGES; k++) begin
                r_d1_v[k] <= 1'b0;
                r_d2_v[k] <= 1'b0;
            end
        end else if (en) begin
            r1_v      <= i_in_valid;
            r2_v      <= r1_v;
            r_d1_v[0] <= r2_v;
            for (int k = 1; k < bpc_pkg::DIV_STAGES; k++) begin
                r_d1_v[k] <= r_d1_v[k-1];
                r_d2_v[k] <= r_d2_v[k-1];
            end
            r3_v      <= r_d1_v[bpc_pkg::DIV_LAST];
            r4_v      <= r3_v;
            r5_v      <= r4_v;
            r6_v      <= r5_v;
            r7_v      <= r6_v;
            r8_v      <= r7_v;
            r_d2_v[0] <= r8_v;
            r9_v      <= r_d2_v[bpc_pkg::DIV_LAST];
            r10_v     <= r9_v;
            r_out_v   <= r10_v;
        end
    end

    // stage 1: temperature product, pressure shift
    logic signed [17:0] w_diff;
    logic signed [34:0] w_prod;
    logic [3:0]         w_sh_amt;
    logic [18:0]        w_up;
    logic signed [34:0] r1_prod;
    logic [18:0]        r1_up;

    assign w_diff   = $signed({2'b00, i_raw_temperature}) - $signed({2'b00, ac6});
    assign w_prod   = 35'(w_diff) * 35'($signed({1'b0, ac5}));
    assign w_sh_amt = 4'd8 - {2'b00, r_oss};
    assign w_up     = 19'(i_raw_pressure_word >> w_sh_amt);

    // stage 2: temperature divisor
    logic signed [19:0] w_x1;
    logic signed [20:0] w_den;
    logic [20:0]        w_den_abs;
    logic [16:0]        w_mc_abs;
    logic signed [19:0] r2_x1;
    logic [18:0]        r2_up;
    logic               r2_neg, r2_flt;
    bpc_pkg::t_div_num  r2_num;
    bpc_pkg::t_div_den  r2_den;

    assign w_x1      = 20'(r1_prod >>> 15);
    assign w_den     = 21'(w_x1) + 21'(md);
    assign w_den_abs = w_den[20] ? 21'(-w_den) : 21'(w_den);
    assign w_mc_abs  = mc[15] ? 17'(-17'(mc)) : 17'(mc);

    // temperature divider and its side words
    bpc_pkg::t_div_num  w_q1;
    logic signed [19:0] r_d1_x1  [bpc_pkg::DIV_STAGES];
    logic [18:0]        r_d1_up  [bpc_pkg::DIV_STAGES];
    logic               r_d1_neg [bpc_pkg::DIV_STAGES];
    logic               r_d1_flt [bpc_pkg::DIV_STAGES];

    bpc_div u_div_temp (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r2_num),
        .i_den (r2_den),
        .o_quo (w_q1)
    );

    // stage 3: b5 and temperature
    logic signed [28:0] w_q1s, w_x2;
    logic signed [29:0] w_b5;
    logic signed [25:0] w_tr;
    logic signed [15:0] w_t;
    logic signed [29:0] r3_b5;
    logic signed [15:0] r3_t;
    logic [18:0]        r3_up;
    logic               r3_flt;

    assign w_q1s = $signed({1'b0, w_q1[27:0]});
    assign w_x2  = r_d1_neg[bpc_pkg::DIV_LAST] ? -w_q1s : w_q1s;
    assign w_b5  = 30'(r_d1_x1[bpc_pkg::DIV_LAST]) + 30'(w_x2);
    assign w_tr  = 26'((w_b5 + 30'sd8) >>> 4);

    always_comb begin
        if (w_tr > 26'(bpc_pkg::T_MAX)) begin
            w_t = 16'(bpc_pkg::T_MAX);
        end else if (w_tr < 26'(bpc_pkg::T_MIN)) begin
            w_t = 16'(bpc_pkg::T_MIN);
        end else begin
            w_t = w_tr[15:0];
        end
    end

    // stage 4: b6 and its square
    logic signed [30:0] w_b6;
    logic signed [61:0] w_b6sq;
    logic signed [30:0] r4_b6;
    logic [55:0]        r4_sq2;
    logic signed [15:0] r4_t;
    logic [18:0]        r4_up;
    logic               r4_flt;

    assign w_b6   = 31'(r3_b5) - 31'(bpc_pkg::TEMP_OFFSET);
    assign w_b6sq = 62'(w_b6) * 62'(w_b6);

    // stage 5: four coefficient products
    logic signed [44:0] w_sqs;
    logic signed [60:0] w_pa, w_pd;
    logic signed [46:0] w_pb, w_pc;
    logic signed [49:0] r5_x1p;
    logic signed [35:0] r5_x2p;
    logic signed [33:0] r5_x1q;
    logic signed [44:0] r5_x2q;
    logic signed [15:0] r5_t;
    logic [18:0]        r5_up;
    logic               r5_flt;

    assign w_sqs = $signed({1'b0, r4_sq2[55:12]});
    assign w_pa  = 61'(b2) * 61'(w_sqs);
    assign w_pb  = 47'(ac2) * 47'(r4_b6);
    assign w_pc  = 47'(ac3) * 47'(r4_b6);
    assign w_pd  = 61'(b1) * 61'(w_sqs);

    // stage 6: sums
    logic signed [46:0] w_s6;
    logic signed [50:0] r6_x3;
    logic signed [44:0] r6_x3q;
    logic signed [15:0] r6_t;
    logic [18:0]        r6_up;
    logic               r6_flt;

    assign w_s6 = 47'(r5_x1q) + 47'(r5_x2q) + 47'sd2;

    // stage 7: b3 and b4
    logic signed [51:0] w_s7;
    logic signed [54:0] w_sh7;
    logic signed [55:0] w_v, w_vb;
    logic [31:0]        w_b4a;
    logic [47:0]        w_b4m;
    logic signed [53:0] r7_b3;
    logic [16:0]        r7_b4;
    logic signed [15:0] r7_t;
    logic [18:0]        r7_up;
    logic               r7_flt;

    assign w_s7  = (52'(ac1) <<< 2) + 52'(r6_x3);
    assign w_sh7 = 55'(w_s7) <<< r_oss;
    assign w_v   = 56'(w_sh7) + 56'sd2;
    assign w_vb  = w_v + (w_v[55] ? 56'sd3 : 56'sd0);
    assign w_b4a = 32'(r6_x3q + 45'sd32768);
    assign w_b4m = 48'(w_b4a) * 48'(ac4);

    // stage 8: b7 and pressure divisor
    logic [31:0]        w_d;
    logic [15:0]        w_k;
    logic [47:0]        w_b7m;
    logic [31:0]        w_b7;
    bpc_pkg::t_div_num  r8_num;
    bpc_pkg::t_div_den  r8_den;
    logic               r8_big, r8_flt;
    logic signed [15:0] r8_t;

    assign w_d   = 32'(55'($signed({1'b0, r7_up})) - 55'(r7_b3));
    assign w_k   = bpc_pkg::B7_SCALE >> r_oss;
    assign w_b7m = 48'(w_d) * 48'(w_k);
    assign w_b7  = w_b7m[31:0];

    // pressure divider and its side words
    bpc_pkg::t_div_num  w_q2;
    logic signed [15:0] r_d2_t   [bpc_pkg::DIV_STAGES];
    logic               r_d2_big [bpc_pkg::DIV_STAGES];
    logic               r_d2_flt [bpc_pkg::DIV_STAGES];

    bpc_div u_div_press (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r8_num),
        .i_den (r8_den),
        .o_quo (w_q2)
    );

    // stage 9: p, its square and the linear term
    logic [32:0]        w_p;
    logic [24:0]        w_pp;
    logic signed [47:0] w_x2m;
    logic [49:0]        r9_pp2;
    logic signed [31:0] r9_x2;
    logic [32:0]        r9_p;
    logic signed [15:0] r9_t;
    logic               r9_flt;

    assign w_p   = r_d2_big[bpc_pkg::DIV_LAST] ? {w_q2, 1'b0} : {1'b0, w_q2};
    assign w_pp  = w_p[32:8];
    assign w_x2m = 48'(bpc_pkg::PCOEF_B) * 48'($signed({1'b0, w_p}));

    // stage 10: quadratic term
    logic [61:0]        w_x1m;
    logic [45:0]        r10_x1;
    logic signed [31:0] r10_x2;
    logic [32:0]        r10_p;
    logic signed [15:0] r10_t;
    logic               r10_flt;

    assign w_x1m = 62'(r9_pp2) * 62'(bpc_pkg::PCOEF_A);

    // stage 11: final sum and saturation
    logic signed [47:0] w_sum, w_pf;
    logic [17:0]        w_psat;
    logic signed [15:0] r_out_t;
    logic [17:0]        r_out_p;
    logic               r_out_flt;

    assign w_sum = 48'($signed({1'b0, r10_x1})) + 48'(r10_x2) + 48'(bpc_pkg::PCOEF_C);
    assign w_pf  = 48'($signed({1'b0, r10_p})) + (w_sum >>> 4);

    always_comb begin
        if (w_pf < 48'sd0) begin
            w_psat = '0;
        end else if (w_pf > 48'(bpc_pkg::P_MAX)) begin
            w_psat = 18'(bpc_pkg::P_MAX);
        end else begin
            w_psat = w_pf[17:0];
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_prod <= w_prod;
            r1_up   <= w_up;

            r2_x1  <= w_x1;
            r2_up  <= r1_up;
            r2_neg <= mc[15] ^ w_den[20];
            r2_flt <= (w_den == 21'sd0);
            r2_num <= bpc_pkg::t_div_num'({w_mc_abs, 11'b0});
            r2_den <= bpc_pkg::t_div_den'(w_den_abs);

            r_d1_x1[0]  <= r2_x1;
            r_d1_up[0]  <= r2_up;
            r_d1_neg[0] <= r2_neg;
            r_d1_flt[0] <= r2_flt;
            for (int k = 1; k < bpc_pkg::DIV_STAGES; k++) begin
                r_d1_x1[k]  <= r_d1_x1[k-1];
                r_d1_up[k]  <= r_d1_up[k-1];
                r_d1_neg[k] <= r_d1_neg[k-1];
                r_d1_flt[k] <= r_d1_flt[k-1];
                r_d2_t[k]   <= r_d2_t[k-1];
                r_d2_big[k] <= r_d2_big[k-1];
                r_d2_flt[k] <= r_d2_flt[k-1];
            end

            r3_b5  <= w_b5;
            r3_t   <= w_t;
            r3_up  <= r_d1_up[bpc_pkg::DIV_LAST];
            r3_flt <= r_d1_flt[bpc_pkg::DIV_LAST];

            r4_b6  <= w_b6;
            r4_sq2 <= w_b6sq[55:0];
            r4_t   <= r3_t;
            r4_up  <= r3_up;
            r4_flt <= r3_flt;

            r5_x1p <= 50'(w_pa >>> 11);
            r5_x2p <= 36'(w_pb >>> 11);
            r5_x1q <= 34'(w_pc >>> 13);
            r5_x2q <= 45'(w_pd >>> 16);
            r5_t   <= r4_t;
            r5_up  <= r4_up;
            r5_flt <= r4_flt;

            r6_x3  <= 51'(r5_x1p) + 51'(r5_x2p);
            r6_x3q <= 45'(w_s6 >>> 2);
            r6_t   <= r5_t;
            r6_up  <= r5_up;
            r6_flt <= r5_flt;

            r7_b3  <= 54'(w_vb >>> 2);
            r7_b4  <= w_b4m[31:15];
            r7_t   <= r6_t;
            r7_up  <= r6_up;
            r7_flt <= r6_flt;

            r8_num <= w_b7[31] ? w_b7 : {w_b7[30:0], 1'b0};
            r8_den <= bpc_pkg::t_div_den'(r7_b4);
            r8_big <= w_b7[31];
            r8_flt <= r7_flt || (r7_b4 == '0);
            r8_t   <= r7_t;

            r_d2_t[0]   <= r8_t;
            r_d2_big[0] <= r8_big;
            r_d2_flt[0] <= r8_flt;

            r9_pp2 <= 50'(w_pp) * 50'(w_pp);
            r9_x2  <= 32'(w_x2m >>> 16);
            r9_p   <= w_p;
            r9_t   <= r_d2_t[bpc_pkg::DIV_LAST];
            r9_flt <= r_d2_flt[bpc_pkg::DIV_LAST];

            r10_x1  <= w_x1m[61:16];
            r10_x2  <= r9_x2;
            r10_p   <= r9_p;
            r10_t   <= r9_t;
            r10_flt <= r9_flt;

            r_out_t   <= r10_flt ? 16'sd0 : r10_t;
            r_out_p   <= r10_flt ? 18'd0 : w_psat;
            r_out_flt <= r10_flt;
        end
    end

    assign o_out_valid          = r_out_v;
    assign o_temperature_tenths = r_out_t;
    assign o_pressure_pa        = r_out_p;
    assign o_divide_fault       = r_out_flt;

`ifndef SYNTHESIS
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_divide_fault |->
            o_temperature_tenths == 16'sd0 && o_pressure_pa == 18'd0)
        else $error("fault word carries nonzero values");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without output back pressure");

    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r1_v)
        else $error("accepted word lost at first stage");

    a_b4_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r8_v && r8_den == '0 |-> r8_flt)
        else $error("zero pressure divisor not flagged");
`endif

endmodule
